// ===== sv/lbs_pkg.sv =====
// Shared constants and types for the skinning unit.
`timescale 1ns / 1ps
package lbs_pkg;
    localparam int MaxJoints  = 64;
    localparam int FracBits   = 16;
    localparam int WeightFrac = 16;
    localparam int EntPerJnt  = 12;
    localparam int Depth      = MaxJoints * EntPerJnt;
    localparam int RowDepth   = MaxJoints * 3;
    localparam int RowAw      = $clog2(RowDepth + 1);
    localparam int JntW       = 6;
    localparam int CntW       = 7;

    localparam logic [0:0] CMD_LOAD = 1'b0;
    localparam logic [0:0] CMD_TERM = 1'b1;
    localparam logic [0:0] REG_LAYOUT = 1'b0;
    localparam logic [0:0] REG_JCOUNT = 1'b1;

    typedef enum logic [2:0] {
        t_IDLE, t_READ, t_MUL, t_SUM, t_WMUL, t_ACC, t_OUT
    } t_state;
endpackage

// ===== sv/lbs_row.sv =====
// One matrix row dotted with a position, scaled by a weight, in phases: products, row sum, weight product.
`timescale 1ns / 1ps
module lbs_row import lbs_pkg::*; (
    input  logic               i_clk,
    input  logic [2:0]         i_phase,
    input  logic signed [31:0] i_m0,
    input  logic signed [31:0] i_m1,
    input  logic signed [31:0] i_m2,
    input  logic signed [31:0] i_m3,
    input  logic signed [31:0] i_px,
    input  logic signed [31:0] i_py,
    input  logic signed [31:0] i_pz,
    input  logic [16:0]        i_w,
    output logic signed [63:0] o_term
);
    logic signed [63:0] r_p0, r_p1, r_p2, r_t, r_a, r_b;
    logic signed [63:0] n_t;
    logic signed [33:0] th;
    logic signed [17:0] w_s;
    logic signed [17:0] tl;

    assign w_s = $signed({1'b0, i_w});
    always_comb begin
        n_t = (r_p0 >>> FracBits) + (r_p1 >>> FracBits) + (r_p2 >>> FracBits)
            + 64'(i_m3);
    end
    // the row sum fits in 49 bits, so its high part fits in 34
    assign th = 34'(r_t >>> WeightFrac);
    assign tl = $signed({2'b00, r_t[15:0]});

    always_ff @(posedge i_clk) begin
        if (i_phase == 3'd0) begin
            r_p0 <= 64'(i_m0) * 64'(i_px);
            r_p1 <= 64'(i_m1) * 64'(i_py);
            r_p2 <= 64'(i_m2) * 64'(i_pz);
        end
        if (i_phase == 3'd1) r_t <= n_t;
        if (i_phase == 3'd2) begin
            // split the weight product into the high part and the low 16 bits
            r_a <= 64'(w_s) * 64'(th);
            r_b <= (64'(w_s) * 64'(tl)) >>> WeightFrac;
        end
    end
    assign o_term = r_a + r_b;
endmodule

// ===== sv/linear_blend_skinning.sv =====
// Linear blend skinning top level: matrix store, accumulators, control.
// Order: a weight term is read row by row, multiplied, summed and weighted, then
// accumulated; after the vertex's last term the result enters the output register.
// Throughput: a new term is taken only once the last is through (stall is high
// while busy); one load per cycle while idle; row reads share the single read port.
// Reset: accumulators, term counter and control clear; layout sparse, 64 joints.
`timescale 1ns / 1ps
module linear_blend_skinning import lbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [0:0]         i_cmd,
    input  logic [5:0]         i_joint,
    input  logic [3:0]         i_elem,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_px,
    input  logic signed [31:0] i_py,
    input  logic signed [31:0] i_pz,
    input  logic [16:0]        i_weight,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic               o_clipped
);
    logic [127:0] mem [RowDepth];
    logic [127:0] r_rd;
    logic [127:0] r_rows [3];
    logic [1:0]   r_ridx;

    t_state r_state, n_state;
    logic r_layout;
    logic [CntW-1:0] r_jcnt, r_tcnt;
    logic signed [63:0] r_acc [3];
    logic signed [31:0] r_px, r_py, r_pz;
    logic [16:0] r_w;
    logic r_use, r_done;
    logic [JntW-1:0] r_sel;
    logic [2:0] phase;
    logic signed [63:0] term [3];
    logic accept, out_free, wr_en;
    logic [CntW-1:0] eff;
    logic [RowAw-1:0] rd_addr;
    logic [1:0] wsel;
    logic [RowAw-1:0] wbase;

    assign out_free = !o_valid || !i_stall;
    assign o_stall  = !i_rst_n || (r_state != t_IDLE);
    assign accept   = i_valid && !o_stall;
    assign eff = (r_jcnt == '0) ? CntW'(1) :
                 (r_jcnt > CntW'(MaxJoints)) ? CntW'(MaxJoints) : r_jcnt;

    // memory: each 128-bit word is one row; byte-lane style column write
    assign wr_en = accept && i_cmd == CMD_LOAD && i_elem < 4'(EntPerJnt);
    assign wsel  = i_elem[1:0];
    assign wbase = RowAw'(i_joint) * RowAw'(3) + RowAw'(i_elem[3:2]);
    assign rd_addr = RowAw'(r_sel) * RowAw'(3) + RowAw'(r_ridx);
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wbase][32*wsel +: 32] <= i_value;
        r_rd <= mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_IDLE: if (accept && i_cmd == CMD_TERM) n_state = t_READ;
            t_READ: if (r_ridx == 2'd3) n_state = t_MUL;
            t_MUL:  n_state = t_SUM;
            t_SUM:  n_state = t_WMUL;
            t_WMUL: n_state = t_ACC;
            t_ACC:  n_state = r_done ? t_OUT : t_IDLE;
            t_OUT:  if (out_free) n_state = t_IDLE;
            default: n_state = t_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_state)
            t_MUL:   phase = 3'd0;
            t_SUM:   phase = 3'd1;
            t_WMUL:  phase = 3'd2;
            default: phase = 3'd7;
        endcase
    end

    genvar g;
    for (g = 0; g < 3; g++) begin : g_row
        lbs_row u_row (
            .i_clk(i_clk), .i_phase(phase),
            .i_m0(r_rows[g][31:0]),  .i_m1(r_rows[g][63:32]),
            .i_m2(r_rows[g][95:64]), .i_m3(r_rows[g][127:96]),
            .i_px(r_px), .i_py(r_py), .i_pz(r_pz), .i_w(r_w),
            .o_term(term[g])
        );
    end

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s;
    endfunction

    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return {1'b1, 32'h7fffffff};
        if (v < -64'sd2147483648) return {1'b1, 32'h80000000};
        return {1'b0, v[31:0]};
    endfunction

    logic [32:0] sx, sy, sz;
    assign sx = sat32(r_acc[0]);
    assign sy = sat32(r_acc[1]);
    assign sz = sat32(r_acc[2]);

    always_ff @(posedge i_clk) begin
        if (r_state == t_IDLE) r_ridx <= '0;
        else if (r_state == t_READ && r_ridx != 2'd3) r_ridx <= r_ridx + 2'd1;
        if (r_state == t_READ && r_ridx != 2'd0) r_rows[r_ridx - 2'd1] <= r_rd;
        if (accept) begin
            r_px <= i_px; r_py <= i_py; r_pz <= i_pz; r_w <= i_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_IDLE;
            r_layout <= 1'b1;
            r_jcnt <= CntW'(MaxJoints);
            r_tcnt <= '0;
            r_acc[0] <= '0; r_acc[1] <= '0; r_acc[2] <= '0;
            r_use <= 1'b0; r_done <= 1'b0; r_sel <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LAYOUT: r_layout <= i_cfg_data[0];
                    REG_JCOUNT: r_jcnt <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == t_OUT && out_free) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
            if (accept && i_cmd == CMD_TERM) begin
                if (!r_layout) begin
                    r_sel  <= r_tcnt[JntW-1:0];
                    r_use  <= r_tcnt < CntW'(MaxJoints);
                    r_done <= (r_tcnt + CntW'(1)) >= eff;
                    r_tcnt <= r_tcnt + CntW'(1);
                end else begin
                    r_sel <= i_joint; r_use <= 1'b1; r_done <= i_last;
                end
            end
            if (r_state == t_ACC && r_use) begin
                r_acc[0] <= sat_add(r_acc[0], term[0]);
                r_acc[1] <= sat_add(r_acc[1], term[1]);
                r_acc[2] <= sat_add(r_acc[2], term[2]);
            end
            if (r_state == t_OUT && out_free) begin
                o_out_x <= sx[31:0]; o_out_y <= sy[31:0]; o_out_z <= sz[31:0];
                o_clipped <= sx[32] | sy[32] | sz[32];
                r_acc[0] <= '0; r_acc[1] <= '0; r_acc[2] <= '0;
                r_tcnt <= '0;
            end
        end
    end

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != t_IDLE) |-> o_stall) else $error("accept while busy");
    a_outhold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tcnt <= CntW'(MaxJoints)) else $error("term count overrun");
endmodule
